[rtl/sprite_quad_vertex_generator_assert.svh]
// Assertion macros for the sprite quad vertex generator.
// Each expects clk and rst in scope.
`ifndef SPRITE_QUAD_VERTEX_GENERATOR_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_GENERATOR_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define SQVG_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define SQVG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/sqvg_pkg.sv]
// ----------------------------------------------------------------------------
// sqvg_pkg
// Shared types and constants for the sprite quad vertex generator.
// ----------------------------------------------------------------------------
package sqvg_pkg;

  localparam int SLOT_COUNT = 31;
  localparam int SLOT_W     = 5;
  localparam int NUM_REGS   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 64;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] width;
    logic signed [31:0] height;
    logic [63:0]        colour_channels;
    logic [31:0]        texture_id;
    logic [63:0]        uv_corner0;
    logic [63:0]        uv_corner1;
    logic [63:0]        uv_corner2;
    logic [63:0]        uv_corner3;
  } sprite_in_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0]        tex_u;
    logic [31:0]        tex_v;
    logic [4:0]         slot;
    logic [31:0]        packed_colour;
    logic               flush_before;
    logic               last_corner;
  } vertex_out_t;

  typedef struct packed {
    logic       load_in;
    logic       compare;
    logic       resolve;
    logic       mac;
    logic [1:0] col;
    logic [1:0] corner;
    logic       emit;
  } sqvg_cmd_t;

  typedef struct packed {
    logic out_busy;
  } sqvg_status_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_COMPARE = 5'b00010,
    ST_RESOLVE = 5'b00100,
    ST_MAC     = 5'b01000,
    ST_EMIT    = 5'b10000
  } sqvg_state_t;

  localparam logic [1:0] COL_X     = 2'd0;
  localparam logic [1:0] COL_Y     = 2'd1;
  localparam logic [1:0] COL_Z     = 2'd2;
  localparam logic [1:0] COL_TRANS = 2'd3;
  localparam logic [1:0] CORNER_LAST = 2'd3;

endpackage

[rtl/sqvg_ctrl.sv]
// ----------------------------------------------------------------------------
// sqvg_ctrl
// Sequencer: accept, slot lookup, then four corners of multiply-accumulate and emit.
// ----------------------------------------------------------------------------
module sqvg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sqvg_pkg::sqvg_status_t st,
  output sqvg_pkg::sqvg_cmd_t    cmd
);

  sqvg_pkg::sqvg_state_t state, state_next;
  logic [1:0] col, col_next;
  logic [1:0] corner, corner_next;

  assign in_stall = (state != sqvg_pkg::ST_IDLE);

  always_comb begin
    state_next  = state;
    col_next    = col;
    corner_next = corner;
    cmd         = '0;
    cmd.col     = col;
    cmd.corner  = corner;
    case (state)
      sqvg_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = sqvg_pkg::ST_COMPARE;
        end
      end
      sqvg_pkg::ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = sqvg_pkg::ST_RESOLVE;
      end
      sqvg_pkg::ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        col_next    = sqvg_pkg::COL_X;
        corner_next = 2'd0;
        state_next  = sqvg_pkg::ST_MAC;
      end
      sqvg_pkg::ST_MAC: begin
        cmd.mac  = 1'b1;
        col_next = col + 2'd1;
        if (col == sqvg_pkg::COL_TRANS) begin
          state_next = sqvg_pkg::ST_EMIT;
        end
      end
      sqvg_pkg::ST_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit = 1'b1;
          col_next = sqvg_pkg::COL_X;
          if (corner == sqvg_pkg::CORNER_LAST) begin
            corner_next = 2'd0;
            state_next  = sqvg_pkg::ST_IDLE;
          end else begin
            corner_next = corner + 2'd1;
            state_next  = sqvg_pkg::ST_MAC;
          end
        end
      end
      default: begin
        state_next = sqvg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sqvg_pkg::ST_IDLE;
      col    <= '0;
      corner <= '0;
    end else begin
      state  <= state_next;
      col    <= col_next;
      corner <= corner_next;
    end
  end

endmodule

[rtl/sqvg_datapath.sv]
// ----------------------------------------------------------------------------
// sqvg_datapath
// Input register, transform matrix, texture slot table, three-row MAC and output register.
// ----------------------------------------------------------------------------
`include "sprite_quad_vertex_generator_assert.svh"

module sqvg_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sqvg_pkg::sprite_in_t                 in_data,
  input  logic                                 cfg_we,
  input  logic [sqvg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sqvg_pkg::CFG_W-1:0]           cfg_data,
  input  sqvg_pkg::sqvg_cmd_t                  cmd,
  output sqvg_pkg::sqvg_status_t               st,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output sqvg_pkg::vertex_out_t                out_data
);

  logic [sqvg_pkg::CFG_W-1:0] matrix [sqvg_pkg::NUM_REGS];

  sqvg_pkg::sprite_in_t in_reg;
  logic signed [32:0] pxw, pyh;

  logic [31:0] slot_table [sqvg_pkg::SLOT_COUNT];
  logic [sqvg_pkg::SLOT_W-1:0] slots_used;
  logic [sqvg_pkg::SLOT_COUNT-1:0] hit;
  logic [sqvg_pkg::SLOT_W-1:0] slot_reg;
  logic flush_reg;

  logic [sqvg_pkg::SLOT_W-1:0] hit_idx;
  logic [sqvg_pkg::SLOT_W-1:0] wr_pos;

  logic [47:0] prod [3];
  logic [47:0] acc  [3];
  logic [31:0] coef_sel [3];
  logic [31:0] trans [3];
  logic signed [32:0] op_sel;
  logic [31:0] colour;
  logic [63:0] uv_sel;

  function automatic logic [7:0] chan8(input logic [15:0] ch);
    logic [23:0] p;
    p = {ch, 8'b0} - {8'b0, ch};
    return (p[23:15] > 9'd255) ? 8'hFF : p[22:15];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix[0] <= 64'h0000_0000_0001_0000;
      matrix[1] <= 64'h0;
      matrix[2] <= 64'h0001_0000_0000_0000;
      matrix[3] <= 64'h0;
      matrix[4] <= 64'h0;
      matrix[5] <= 64'h0000_0000_0001_0000;
    end else if (cfg_we && (cfg_index < 3'(sqvg_pkg::NUM_REGS))) begin
      matrix[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_reg <= in_data;
    end
    if (cmd.compare) begin
      pxw <= 33'(in_reg.pos_x) + 33'(in_reg.width);
      pyh <= 33'(in_reg.pos_y) + 33'(in_reg.height);
      for (int i = 0; i < sqvg_pkg::SLOT_COUNT; i++) begin
        hit[i] <= (slot_table[i] == in_reg.texture_id) &&
                  (sqvg_pkg::SLOT_W'(i) < slots_used);
      end
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = sqvg_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = sqvg_pkg::SLOT_W'(i);
      end
    end
  end

  assign wr_pos = (slots_used >= sqvg_pkg::SLOT_W'(sqvg_pkg::SLOT_COUNT)) ? '0 : slots_used;

  always_ff @(posedge clk) begin
    if (cmd.resolve && (in_reg.texture_id != 32'd0) && (hit == '0)) begin
      slot_table[wr_pos] <= in_reg.texture_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
      slot_reg   <= '0;
      flush_reg  <= 1'b0;
    end else if (cmd.resolve) begin
      flush_reg <= 1'b0;
      if (in_reg.texture_id == 32'd0) begin
        slot_reg <= '0;
      end else if (hit != '0) begin
        slot_reg <= hit_idx + 5'd1;
      end else begin
        flush_reg  <= (slots_used >= sqvg_pkg::SLOT_W'(sqvg_pkg::SLOT_COUNT));
        slots_used <= wr_pos + 5'd1;
        slot_reg   <= wr_pos + 5'd1;
      end
    end
  end

  always_comb begin
    case (cmd.col)
      sqvg_pkg::COL_X: op_sel = cmd.corner[1] ? pxw : 33'(in_reg.pos_x);
      sqvg_pkg::COL_Y: op_sel = (cmd.corner == 2'd1 || cmd.corner == 2'd2) ?
                                pyh : 33'(in_reg.pos_y);
      sqvg_pkg::COL_Z: op_sel = 33'(in_reg.pos_z);
      default:         op_sel = '0;
    endcase
    for (int r = 0; r < 3; r++) begin
      trans[r] = matrix[2*r+1][63:32];
      case (cmd.col)
        sqvg_pkg::COL_X: coef_sel[r] = matrix[2*r][31:0];
        sqvg_pkg::COL_Y: coef_sel[r] = matrix[2*r][63:32];
        sqvg_pkg::COL_Z: coef_sel[r] = matrix[2*r+1][31:0];
        default:         coef_sel[r] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac) begin
      for (int r = 0; r < 3; r++) begin
        prod[r] <= 48'($signed({{16{coef_sel[r][31]}}, coef_sel[r]}) *
                       $signed({{15{op_sel[32]}}, op_sel}));
        if (cmd.col == sqvg_pkg::COL_X) begin
          acc[r] <= {trans[r], 16'b0};
        end else begin
          acc[r] <= acc[r] + prod[r];
        end
      end
    end
  end

  assign colour = {chan8(in_reg.colour_channels[63:48]), chan8(in_reg.colour_channels[47:32]),
                   chan8(in_reg.colour_channels[31:16]), chan8(in_reg.colour_channels[15:0])};

  always_comb begin
    case (cmd.corner)
      2'd0:    uv_sel = in_reg.uv_corner0;
      2'd1:    uv_sel = in_reg.uv_corner1;
      2'd2:    uv_sel = in_reg.uv_corner2;
      default: uv_sel = in_reg.uv_corner3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.vert_x        <= acc[0][47:16];
      out_data.vert_y        <= acc[1][47:16];
      out_data.vert_z        <= acc[2][47:16];
      out_data.tex_u         <= uv_sel[31:0];
      out_data.tex_v         <= uv_sel[63:32];
      out_data.slot          <= slot_reg;
      out_data.packed_colour <= colour;
      out_data.flush_before  <= flush_reg && (cmd.corner == 2'd0);
      out_data.last_corner   <= (cmd.corner == sqvg_pkg::CORNER_LAST);
    end
  end

  assign st.out_busy = out_valid && out_stall;

  `SQVG_CHECK(a_used_bound, slots_used <= sqvg_pkg::SLOT_W'(sqvg_pkg::SLOT_COUNT), "slots_used over table size")
  `SQVG_CHECK(a_slot_nonzero, cmd.resolve && (in_reg.texture_id != 32'd0) |=> slot_reg != 5'd0, "textured sprite got slot zero")
  `SQVG_CHECK(a_emit_valid, cmd.emit |=> out_valid, "emit did not raise out_valid")
  `SQVG_NEVER(a_emit_busy, cmd.emit && out_valid && out_stall, "emit overwrote a stalled vertex")

endmodule

[rtl/sprite_quad_vertex_generator.sv]
// Sprites are accepted only while idle; in_stall is high until the last vertex
// is emitted. The texture slot lookup runs in the compare and resolve states.
// Each vertex passes the shared 3-row multiply-accumulate (x, y, z, translation)
// and is loaded into the output register in emit, held off while a vertex stalls.
// Reset (rst, synchronous) restores the identity matrix and empties the slot table.
// ----------------------------------------------------------------------------
// sprite_quad_vertex_generator
// Expands one sprite into four transformed, textured, colored quad vertices.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sqvg_pkg::sprite_in_t             in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sqvg_pkg::vertex_out_t            out_data,
  input  logic                             cfg_we,
  input  logic [sqvg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sqvg_pkg::CFG_W-1:0]       cfg_data
);

  sqvg_pkg::sqvg_cmd_t    cmd;
  sqvg_pkg::sqvg_status_t st;

  sqvg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  sqvg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
